@@ sv/pabs_pkg.sv @@
// Package for the pixel alpha blend store.
// Item and register types, status and operation codes, blend constants.
// No dependencies.
package pabs_pkg;

  localparam logic OP_BLEND = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [2:0] ST_WRITTEN   = 3'd0;
  localparam logic [2:0] ST_OFF_IMAGE = 3'd1;
  localparam logic [2:0] ST_ZERO_SKIP = 3'd2;
  localparam logic [2:0] ST_READ_DONE = 3'd3;
  localparam logic [2:0] ST_READ_OFF  = 3'd4;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [8:0]  ALPHA_ONE    = 9'd256;
  localparam logic [23:0] RGB_MASK     = 24'hFFFFFF;
  localparam logic [7:0]  REG_RESET    = 8'd128;

  typedef struct packed {
    logic              operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [23:0]        rgb_color;
    logic [7:0]         src_alpha;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [1:0] reg_index;
    logic [7:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic [7:0] width;
    logic [7:0] height;
  } limits_t;

endpackage

@@ sv/pabs_stream_if.sv @@
// Valid/ready channel carrying one item of type T.
// Used for the request, result and configuration channels; no dependencies.
interface pabs_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ sv/pabs_cfg.sv @@
// Configuration registers: active image width and height, clamped to the built size.
// Depends on pabs_pkg and pabs_stream_if.
module pabs_cfg #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic              clk,
  input  logic              rst,
  pabs_stream_if.sink       cfg,
  output pabs_pkg::limits_t limits
);
  import pabs_pkg::*;

  localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);

  logic [7:0] image_width;
  logic [7:0] image_height;
  cfg_item_t  wr;

  assign wr        = cfg.data;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= REG_RESET;
      image_height <= REG_RESET;
    end else if (cfg.valid) begin
      unique case (wr.reg_index)
        REG_IMAGE_WIDTH:  image_width  <= wr.value;
        REG_IMAGE_HEIGHT: image_height <= wr.value;
        default: ;
      endcase
    end
  end

  // a limit above the built size saturates to it, which then fits 8 bits
  assign limits.width  = ({5'd0, image_width} > MAXW) ? MAXW[7:0] : image_width;
  assign limits.height = ({5'd0, image_height} > MAXH) ? MAXH[7:0] : image_height;

endmodule

@@ sv/pabs_frame_mem.sv @@
// Frame store: one synchronous RAM, registered read, one write port.
// Clears itself after reset, one word per cycle. Depends on nothing.
module pabs_frame_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  output logic          clearing
);

  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/pabs_blend.sv @@
// Source-over blend of an RGB color with coverage alpha onto an ARGB pixel.
// Depends on pabs_pkg.
module pabs_blend (
  input  logic [31:0] bg,
  input  logic [23:0] color,
  input  logic [7:0]  alpha,
  output logic [31:0] word
);
  import pabs_pkg::*;

  logic [7:0]  ba;
  logic [8:0]  ia;
  logic [16:0] sum_r, sum_g, sum_b;
  logic [16:0] prod_a;
  logic [8:0]  acc_a;
  logic [7:0]  out_a;

  assign ba = bg[31:24];
  assign ia = ALPHA_ONE - {1'b0, alpha};

  assign sum_r = 17'(color[23:16]) * 17'(alpha) + 17'(bg[23:16]) * 17'(ia);
  assign sum_g = 17'(color[15:8])  * 17'(alpha) + 17'(bg[15:8])  * 17'(ia);
  assign sum_b = 17'(color[7:0])   * 17'(alpha) + 17'(bg[7:0])   * 17'(ia);
  assign prod_a = 17'(ba) * 17'(ia);
  assign acc_a  = {1'b0, alpha} + {1'b0, prod_a[15:8]};
  assign out_a  = acc_a[8] ? ALPHA_OPAQUE : acc_a[7:0];

  always_comb begin
    if (alpha == ALPHA_OPAQUE) begin
      word = {ALPHA_OPAQUE, color & RGB_MASK};
    end else if (ba == 8'd0) begin
      word = {alpha, color & RGB_MASK};
    end else begin
      word = {out_a, sum_r[15:8], sum_g[15:8], sum_b[15:8]};
    end
  end

endmodule

@@ sv/pixel_alpha_blend_store_top.sv @@
// Pixel alpha blend store: an ARGB framebuffer with a source-over blend unit.
// Depends on pabs_pkg, pabs_stream_if, pabs_cfg, pabs_frame_mem, pabs_blend.
//
// Channels: request (sink) takes blend or read items, result (source) gives one
// item per request, cfg (sink) writes image width and height, always ready.
// An item is moved when valid and ready are both high.
// The address (row times width plus column) is formed as a request is accepted
// and registered into the read stage s1, which reads the RAM; the blend stage
// s2 blends the registered word and writes it back. A new request is taken only
// while s1 is empty and s2 is empty or finishing, so one item is in flight at a
// time and a read never sees a stale word.
// Reset: the registers return to 128 by 128 and the RAM is cleared, one word a
// cycle; request stays low until the clear ends, cfg is taken throughout.
// Stall: the result register holds while result.ready is low; one more request
// is taken and waits after its RAM read, then request drops until the result
// register frees.
module pixel_alpha_blend_store_top #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic         clk,
  input  logic         rst,
  pabs_stream_if.sink   request,
  pabs_stream_if.source result,
  pabs_stream_if.sink   cfg
);
  import pabs_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (AW > 16) ? AW : 16;

  limits_t   limits;
  in_item_t  req;
  out_item_t res;

  logic          off;
  logic [15:0]   row_base;
  logic [IW-1:0] idx;

  logic          s1_v, s1_op, s1_off;
  logic [AW-1:0] s1_addr;
  logic [23:0]   s1_color;
  logic [7:0]    s1_alpha;

  logic          s2_v, s2_op, s2_off;
  logic [AW-1:0] s2_addr;
  logic [23:0]   s2_color;
  logic [7:0]    s2_alpha;
  logic          s2_done;

  logic [31:0]   rd_data;
  logic [31:0]   blended;
  logic          wr_en;
  logic          clearing;
  logic          accept;

  pabs_cfg #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .limits (limits)
  );

  pabs_frame_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (s1_v),
    .rd_addr  (s1_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (s2_addr),
    .wr_data  (blended),
    .clearing (clearing)
  );

  pabs_blend u_blend (
    .bg    (rd_data),
    .color (s2_color),
    .alpha (s2_alpha),
    .word  (blended)
  );

  assign req = request.data;

  assign off = req.pos_x[15] || req.pos_y[15] ||
               (req.pos_x >= $signed({8'd0, limits.width})) ||
               (req.pos_y >= $signed({8'd0, limits.height}));

  assign row_base = 16'(req.pos_y[7:0]) * 16'(limits.width);
  assign idx      = IW'(row_base) + IW'(req.pos_x[7:0]);

  assign s2_done       = s2_v && (!result.valid || result.ready);
  assign request.ready = !clearing && !s1_v && (!s2_v || s2_done);
  assign accept        = request.valid && request.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= accept;
      if (s1_v) begin
        s2_v <= 1'b1;
      end else if (s2_done) begin
        s2_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= req.operation;
      s1_off   <= off;
      s1_addr  <= idx[AW-1:0];
      s1_color <= req.rgb_color;
      s1_alpha <= req.src_alpha;
    end
    if (s1_v) begin
      s2_op    <= s1_op;
      s2_off   <= s1_off;
      s2_addr  <= s1_addr;
      s2_color <= s1_color;
      s2_alpha <= s1_alpha;
    end
  end

  assign wr_en = s2_done && !s2_off && (s2_op == OP_BLEND) && (s2_alpha != 8'd0);

  always_comb begin
    if (s2_off) begin
      res.pixel_word = '0;
      res.status     = (s2_op == OP_READ) ? ST_READ_OFF : ST_OFF_IMAGE;
    end else if (s2_op == OP_READ) begin
      res.pixel_word = rd_data;
      res.status     = ST_READ_DONE;
    end else if (s2_alpha == 8'd0) begin
      res.pixel_word = rd_data;
      res.status     = ST_ZERO_SKIP;
    end else begin
      res.pixel_word = blended;
      res.status     = ST_WRITTEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s2_done) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_done) begin
      result.data <= res;
    end
  end

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !wr_en)
    else $error("write-back during clearing pass");

  a_single_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s1_v && s2_v))
    else $error("two items in flight");

  a_read_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_v && !s2_v)
    else $error("accepted item did not enter the read stage");

  a_result_follows_done: assert property (@(posedge clk) disable iff (rst)
    s2_done |=> result.valid)
    else $error("finished item not presented");

endmodule

@@ dv/tb_pixel_alpha_blend_store_top.sv @@
// Testbench for pixel_alpha_blend_store_top: directed vectors, then random blend and
// read items under several image sizes, checked against a source-over predictor.
// Depends on pabs_pkg, pabs_stream_if and the block under test.
module tb_pixel_alpha_blend_store_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pabs_pkg::*;

  localparam int MAX_W = 128;
  localparam int MAX_H = 128;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int LONG_HOLD = 300;
  localparam int NUM_PHASES = 9;
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  localparam int PH_WIDTH[NUM_PHASES]  = '{128, 1, 255, 0, 7, 128, 3, 16, 128};
  localparam int PH_HEIGHT[NUM_PHASES] = '{128, 1, 200, 5, 3, 1, 128, 0, 128};
  localparam int PH_ITEMS[NUM_PHASES]  = '{90, 70, 90, 50, 90, 90, 90, 40, 100};
  localparam bit PH_SPARE[NUM_PHASES]  = '{0, 0, 0, 0, 1, 0, 0, 0, 0};
  localparam bit PH_HOLD[NUM_PHASES]   = '{1, 0, 0, 0, 0, 1, 0, 0, 0};

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } vector_t;

  logic clk;
  logic rst;

  pabs_stream_if #(.T(in_item_t))  req_ch ();
  pabs_stream_if #(.T(out_item_t)) res_ch ();
  pabs_stream_if #(.T(cfg_item_t)) cfg_ch ();

  pixel_alpha_blend_store_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .request(req_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  logic [31:0] shadow_frame [MAX_W*MAX_H];
  logic [7:0]  shadow_width;
  logic [7:0]  shadow_height;
  out_item_t   awaited_outcomes[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_request = 0;
  int          hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned active_extent(logic [7:0] r, int unsigned limit);
    return (r > limit) ? limit : r;
  endfunction

  function automatic logic [31:0] blend_source_over(logic [31:0] bg, logic [23:0] rgb,
                                                    logic [7:0] a);
    int unsigned inv;
    int unsigned ch;
    int unsigned out_a;
    logic [31:0] word;
    if (a == ALPHA_OPAQUE) return {ALPHA_OPAQUE, rgb};
    if (bg[31:24] == 8'd0) return {a, rgb};
    inv = ALPHA_ONE - a;
    for (int c = 0; c < 3; c++) begin
      ch = (rgb[c*8 +: 8] * a + bg[c*8 +: 8] * inv) >> 8;
      word[c*8 +: 8] = ch[7:0];
    end
    out_a = a + ((bg[31:24] * inv) >> 8);
    if (out_a > ALPHA_OPAQUE) out_a = ALPHA_OPAQUE;
    word[31:24] = out_a[7:0];
    return word;
  endfunction

  // Updates the shadow frame for blends that write.
  function automatic out_item_t predict_outcome(in_item_t it);
    int unsigned w;
    int unsigned h;
    int unsigned addr;
    logic [15:0] xu;
    logic [15:0] yu;
    out_item_t   r;
    w  = active_extent(shadow_width, MAX_W);
    h  = active_extent(shadow_height, MAX_H);
    xu = it.pos_x;
    yu = it.pos_y;
    if (xu[15] || yu[15] || xu >= w || yu >= h) begin
      r.pixel_word = '0;
      r.status     = (it.operation == OP_READ) ? ST_READ_OFF : ST_OFF_IMAGE;
      return r;
    end
    addr = yu * w + xu;
    r.pixel_word = shadow_frame[addr];
    if (it.operation == OP_READ) begin
      r.status = ST_READ_DONE;
    end else if (it.src_alpha == 8'd0) begin
      r.status = ST_ZERO_SKIP;
    end else begin
      r.pixel_word = blend_source_over(r.pixel_word, it.rgb_color, it.src_alpha);
      shadow_frame[addr] = r.pixel_word;
      r.status = ST_WRITTEN;
    end
    return r;
  endfunction

  function automatic vector_t vec(logic op, logic signed [15:0] x, logic signed [15:0] y,
                                  logic [23:0] rgb, logic [7:0] a, logic typed,
                                  logic [31:0] word, logic [2:0] st);
    vector_t v;
    v.item.operation  = op;
    v.item.pos_x      = x;
    v.item.pos_y      = y;
    v.item.rgb_color  = rgb;
    v.item.src_alpha  = a;
    v.typed           = typed;
    v.want.pixel_word = word;
    v.want.status     = st;
    return v;
  endfunction

  // Mostly a few hot pixels near the corners so blends land on covered pixels.
  function automatic logic [15:0] pick_coord(int unsigned lim);
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(99);
    span = (lim < 4) ? lim : 4;
    if (lim != 0 && pick < 45) return 16'($urandom_range(span - 1));
    if (lim != 0 && pick < 60) return 16'(lim - 1 - $urandom_range(span - 1));
    if (pick < 82) return 16'($urandom_range(lim + 1) - 1);
    return 16'($urandom);
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    it.operation = ($urandom_range(99) < 20) ? OP_READ : OP_BLEND;
    it.pos_x     = pick_coord(active_extent(shadow_width, MAX_W));
    it.pos_y     = pick_coord(active_extent(shadow_height, MAX_H));
    it.rgb_color = 24'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) it.src_alpha = 8'd0;
    else if (pick < 30) it.src_alpha = ALPHA_OPAQUE;
    else if (pick < 38) it.src_alpha = pick[0] ? 8'd1 : ALPHA_OPAQUE - 8'd1;
    else it.src_alpha = 8'($urandom);
    return it;
  endfunction

  task automatic write_register(logic [1:0] idx, logic [7:0] val);
    cfg_ch.data  <= {idx, val};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) shadow_width = val;
    else if (idx == REG_IMAGE_HEIGHT) shadow_height = val;
  endtask

  task automatic send_request(in_item_t it, logic typed, out_item_t want);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.data  <= it;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    predicted = predict_outcome(it);
    awaited_outcomes.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    while (awaited_outcomes.size() != 0) @(posedge clk);
  endtask

  // result side: checks each item and drives ready, with an optional long hold-off
  initial begin
    out_item_t want;
    out_item_t got;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (awaited_outcomes.size() == 0) begin
          $error("unexpected result: pixel_word %h status %0d", got.pixel_word, got.status);
          errors++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (got.pixel_word !== want.pixel_word) begin
            $error("pixel_word: expected %h, actual %h", want.pixel_word, got.pixel_word);
            errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    vector_t directed[$];
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    foreach (shadow_frame[k]) shadow_frame[k] = '0;
    shadow_width  = REG_RESET;
    shadow_height = REG_RESET;

    // store cleared at reset, off-image corners, zero alpha, opaque, first coverage
    directed.push_back(vec(OP_READ, 0, 0, 24'h0, 8'h0, 1, 32'h0, ST_READ_DONE));
    directed.push_back(vec(OP_READ, 127, 127, RGB_MASK, ALPHA_OPAQUE, 1, 32'h0, ST_READ_DONE));
    directed.push_back(vec(OP_READ, -1, 0, 24'h0, 8'h0, 1, 32'h0, ST_READ_OFF));
    directed.push_back(vec(OP_READ, 0, -32768, 24'h0, 8'h0, 1, 32'h0, ST_READ_OFF));
    directed.push_back(vec(OP_READ, 128, 5, 24'h0, 8'h0, 1, 32'h0, ST_READ_OFF));
    directed.push_back(vec(OP_BLEND, 0, 128, 24'h123456, ALPHA_OPAQUE, 1, 32'h0,
                           ST_OFF_IMAGE));
    directed.push_back(vec(OP_BLEND, 32767, 32767, RGB_MASK, 8'h80, 1, 32'h0, ST_OFF_IMAGE));
    directed.push_back(vec(OP_BLEND, -32768, -1, RGB_MASK, ALPHA_OPAQUE, 1, 32'h0,
                           ST_OFF_IMAGE));
    directed.push_back(vec(OP_BLEND, 5, 5, 24'h123456, 8'h0, 1, 32'h0, ST_ZERO_SKIP));
    directed.push_back(vec(OP_BLEND, 5, 5, RGB_MASK, ALPHA_OPAQUE, 1, 32'hFFFF_FFFF,
                           ST_WRITTEN));
    directed.push_back(vec(OP_BLEND, 6, 5, 24'hABCDEF, 8'h01, 1, 32'h01AB_CDEF, ST_WRITTEN));
    directed.push_back(vec(OP_BLEND, 6, 5, 24'h000000, 8'h80, 0, '0, '0));
    directed.push_back(vec(OP_BLEND, 5, 5, 24'h000000, 8'hFE, 0, '0, '0));
    directed.push_back(vec(OP_BLEND, 5, 5, 24'h654321, 8'h00, 0, '0, '0));
    directed.push_back(vec(OP_READ, 5, 5, 24'h0, 8'h0, 0, '0, '0));
    directed.push_back(vec(OP_READ, 6, 5, 24'h0, 8'h0, 0, '0, '0));
    directed.push_back(vec(OP_BLEND, 127, 127, 24'h00FF00, ALPHA_OPAQUE, 1, 32'hFF00_FF00,
                           ST_WRITTEN));
    directed.push_back(vec(OP_BLEND, 127, 127, 24'hFF00FF, 8'h80, 0, '0, '0));
    directed.push_back(vec(OP_BLEND, 127, 127, RGB_MASK, 8'h01, 0, '0, '0));
    directed.push_back(vec(OP_READ, 127, 127, 24'h0, 8'h0, 0, '0, '0));
    directed.push_back(vec(OP_BLEND, 0, 0, 24'h000000, ALPHA_OPAQUE, 1, 32'hFF00_0000,
                           ST_WRITTEN));
    directed.push_back(vec(OP_READ, 0, 0, 24'h0, 8'h0, 1, 32'hFF00_0000, ST_READ_DONE));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_request(directed[i].item, directed[i].typed, directed[i].want);
    req_ch.valid <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      send_idle_pct = (ph < 3) ? 32 : (ph < 6) ? 81 : 0;
      recv_idle_pct = (ph < 3) ? 81 : (ph < 6) ? 32 : 0;
      write_register(REG_IMAGE_WIDTH, 8'(PH_WIDTH[ph]));
      write_register(REG_IMAGE_HEIGHT, 8'(PH_HEIGHT[ph]));
      if (PH_SPARE[ph]) begin
        // unused indexes must leave the size alone
        write_register(REG_SPARE_A, 8'd0);
        write_register(REG_SPARE_B, 8'hFF);
      end
      if (PH_HOLD[ph]) hold_request = 1'b1;
      for (int n = 0; n < PH_ITEMS[ph]; n++) send_request(random_item(), 1'b0, '0);
      req_ch.valid <= 1'b0;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pabs_pkg.sv
sv/pabs_stream_if.sv
sv/pabs_cfg.sv
sv/pabs_frame_mem.sv
sv/pabs_blend.sv
sv/pixel_alpha_blend_store_top.sv
dv/tb_pixel_alpha_blend_store_top.sv
